[rtl/pointwise_scalar_wave_flux_core_defines.svh]
// ----------------------------------------------------------------------------
// pointwise_scalar_wave_flux_core_defines
// assertion macros shared by the flux core files
// ----------------------------------------------------------------------------
`ifndef POINTWISE_SCALAR_WAVE_FLUX_CORE_DEFINES_SVH
`define POINTWISE_SCALAR_WAVE_FLUX_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PSW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flux core check failed");

// next-cycle implication, checked out of reset
`define PSW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flux core check failed");

`endif

[rtl/psw_pkg.sv]
// ----------------------------------------------------------------------------
// psw_pkg
// widths, sideband types and fixed-point helpers for the flux core
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int WORD_BITS   = 32;   // saturation width, 16..32
    localparam int FRAC_BITS   = 16;
    localparam int IN_BITS     = 32;
    localparam int PROD_BITS   = 2 * IN_BITS - FRAC_BITS;
    localparam int LANES       = 4;
    localparam int NUM_BITS    = 2 * IN_BITS;
    localparam int ROOT_BITS   = NUM_BITS / 2;
    localparam int SQRT_STAGES = ROOT_BITS;
    localparam int DIV_STAGES  = NUM_BITS;
    localparam int SDOT_BITS   = PROD_BITS + 2;

    localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_MIN = -(64'sd1 <<< (WORD_BITS - 1));

    typedef logic signed [IN_BITS-1:0]   word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    typedef struct packed {
        prod_t                        sbp_x;
        prod_t                        sbp_y;
        prod_t                        sbp_z;
        logic signed [SDOT_BITS-1:0]  sdot;
        logic                         bad;
    } psw_side_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_BITS-1:0] num;
        psw_side_t                      side;
    } psw_root_side_t;

    // floored q16.16 product
    function automatic prod_t qmul(input word_t a, input word_t b);
        logic signed [NUM_BITS-1:0] p;
        p = a * b;
        return p[NUM_BITS-1:FRAC_BITS];
    endfunction

    function automatic word_t sat_word(input logic signed [63:0] v);
        word_t r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[IN_BITS-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[IN_BITS-1:0];
        end
        else
        begin
            r = v[IN_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/psw_front.sv]
// ----------------------------------------------------------------------------
// psw_front
// five-stage front end: cofactors, determinant, dot products, numerators
// ----------------------------------------------------------------------------
module psw_front
    import psw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [63:0]          metric_xx_xy,
    input  logic [63:0]          metric_xz_yy,
    input  logic [63:0]          metric_yz_zz,
    input  word_t                lapse,
    input  word_t                shift_x,
    input  word_t                shift_y,
    input  word_t                shift_z,
    input  word_t                momentum,
    input  word_t                grad_x,
    input  word_t                grad_y,
    input  word_t                grad_z,
    output logic                 out_valid,
    output logic [NUM_BITS-1:0]  radicand,
    output psw_root_side_t       out_side
);

    word_t xx, xy, xz, yy, yz, zz;
    assign xx = metric_xx_xy[31:0];
    assign xy = metric_xx_xy[63:32];
    assign xz = metric_xz_yy[31:0];
    assign yy = metric_xz_yy[63:32];
    assign yz = metric_yz_zz[31:0];
    assign zz = metric_yz_zz[63:32];

    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg;

    // stage a: metric pair products, shift products
    prod_t a_p_reg [12];
    prod_t a_sbp_reg [3];
    prod_t a_sg_reg [3];
    word_t a_m_reg [3];
    word_t a_g_reg [3];
    word_t a_alp_reg, a_pi_reg;

    // stage b: cofactors
    word_t b_c_reg [6];
    word_t b_m_reg [3];
    word_t b_g_reg [3];
    word_t b_alp_reg, b_pi_reg;
    prod_t b_sbp_reg [3];
    logic signed [SDOT_BITS-1:0] b_sdot_reg;

    // stage c: determinant terms and cofactor-gradient products
    prod_t c_det_reg [3];
    prod_t c_dp_reg [9];
    word_t c_alp_reg, c_pi_reg;
    prod_t c_sbp_reg [3];
    logic signed [SDOT_BITS-1:0] c_sdot_reg;

    // stage d: sums
    logic signed [SDOT_BITS-1:0] d_det_reg;
    word_t d_dot_reg [3];
    word_t d_alp_reg, d_pi_reg;
    prod_t d_sbp_reg [3];
    logic signed [SDOT_BITS-1:0] d_sdot_reg;

    // stage e: numerators
    logic [NUM_BITS-1:0] e_rad_reg;
    psw_root_side_t      e_side_reg;

    logic signed [SDOT_BITS-1:0] det_next;
    assign det_next = SDOT_BITS'(c_det_reg[0]) + SDOT_BITS'(c_det_reg[1])
                    + SDOT_BITS'(c_det_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_p_reg[0]  <= qmul(yy, zz);
            a_p_reg[1]  <= qmul(yz, yz);
            a_p_reg[2]  <= qmul(xz, yz);
            a_p_reg[3]  <= qmul(xy, zz);
            a_p_reg[4]  <= qmul(xy, yz);
            a_p_reg[5]  <= qmul(xz, yy);
            a_p_reg[6]  <= qmul(xx, zz);
            a_p_reg[7]  <= qmul(xz, xz);
            a_p_reg[8]  <= qmul(xy, xz);
            a_p_reg[9]  <= qmul(xx, yz);
            a_p_reg[10] <= qmul(xx, yy);
            a_p_reg[11] <= qmul(xy, xy);
            a_sbp_reg[0] <= qmul(shift_x, momentum);
            a_sbp_reg[1] <= qmul(shift_y, momentum);
            a_sbp_reg[2] <= qmul(shift_z, momentum);
            a_sg_reg[0]  <= qmul(shift_x, grad_x);
            a_sg_reg[1]  <= qmul(shift_y, grad_y);
            a_sg_reg[2]  <= qmul(shift_z, grad_z);
            a_m_reg[0] <= xx;
            a_m_reg[1] <= xy;
            a_m_reg[2] <= xz;
            a_g_reg[0] <= grad_x;
            a_g_reg[1] <= grad_y;
            a_g_reg[2] <= grad_z;
            a_alp_reg  <= lapse;
            a_pi_reg   <= momentum;

            for (int k = 0; k < 6; k++)
            begin
                b_c_reg[k] <= sat_word(64'(a_p_reg[2*k]) - 64'(a_p_reg[2*k+1]));
            end
            b_m_reg    <= a_m_reg;
            b_g_reg    <= a_g_reg;
            b_alp_reg  <= a_alp_reg;
            b_pi_reg   <= a_pi_reg;
            b_sbp_reg  <= a_sbp_reg;
            b_sdot_reg <= SDOT_BITS'(a_sg_reg[0]) + SDOT_BITS'(a_sg_reg[1])
                        + SDOT_BITS'(a_sg_reg[2]);

            // cofactor order: xx xy xz yy yz zz
            c_det_reg[0] <= qmul(b_m_reg[0], b_c_reg[0]);
            c_det_reg[1] <= qmul(b_m_reg[1], b_c_reg[1]);
            c_det_reg[2] <= qmul(b_m_reg[2], b_c_reg[2]);
            c_dp_reg[0] <= qmul(b_c_reg[0], b_g_reg[0]);
            c_dp_reg[1] <= qmul(b_c_reg[1], b_g_reg[1]);
            c_dp_reg[2] <= qmul(b_c_reg[2], b_g_reg[2]);
            c_dp_reg[3] <= qmul(b_c_reg[1], b_g_reg[0]);
            c_dp_reg[4] <= qmul(b_c_reg[3], b_g_reg[1]);
            c_dp_reg[5] <= qmul(b_c_reg[4], b_g_reg[2]);
            c_dp_reg[6] <= qmul(b_c_reg[2], b_g_reg[0]);
            c_dp_reg[7] <= qmul(b_c_reg[4], b_g_reg[1]);
            c_dp_reg[8] <= qmul(b_c_reg[5], b_g_reg[2]);
            c_alp_reg  <= b_alp_reg;
            c_pi_reg   <= b_pi_reg;
            c_sbp_reg  <= b_sbp_reg;
            c_sdot_reg <= b_sdot_reg;

            d_det_reg <= det_next;
            for (int k = 0; k < 3; k++)
            begin
                d_dot_reg[k] <= sat_word(64'(c_dp_reg[3*k]) + 64'(c_dp_reg[3*k+1])
                                         + 64'(c_dp_reg[3*k+2]));
            end
            d_alp_reg  <= c_alp_reg;
            d_pi_reg   <= c_pi_reg;
            d_sbp_reg  <= c_sbp_reg;
            d_sdot_reg <= c_sdot_reg;

            e_rad_reg <= {d_det_reg[PROD_BITS-1:0], {FRAC_BITS{1'b0}}};
            for (int k = 0; k < 3; k++)
            begin
                e_side_reg.num[k] <= d_alp_reg * d_dot_reg[k];
            end
            e_side_reg.num[3]     <= d_alp_reg * d_pi_reg;
            e_side_reg.side.sbp_x <= d_sbp_reg[0];
            e_side_reg.side.sbp_y <= d_sbp_reg[1];
            e_side_reg.side.sbp_z <= d_sbp_reg[2];
            e_side_reg.side.sdot  <= d_sdot_reg;
            e_side_reg.side.bad   <= (d_det_reg <= 0);
        end
    end

    assign out_valid = ve_reg;
    assign radicand  = e_rad_reg;
    assign out_side  = e_side_reg;

endmodule

[rtl/psw_sqrt.sv]
// ----------------------------------------------------------------------------
// psw_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module psw_sqrt
    import psw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUM_BITS-1:0]  radicand,
    input  psw_root_side_t       in_side,
    output logic                 out_valid,
    output logic [ROOT_BITS-1:0] root,
    output psw_root_side_t       out_side
);

    logic                 v_reg    [SQRT_STAGES];
    logic [ROOT_BITS+1:0] rem_reg  [SQRT_STAGES];
    logic [ROOT_BITS-1:0] q_reg    [SQRT_STAGES];
    logic [NUM_BITS-1:0]  n_reg    [SQRT_STAGES];
    psw_root_side_t       side_reg [SQRT_STAGES];

    logic [ROOT_BITS+1:0] rem_next [SQRT_STAGES];
    logic [ROOT_BITS-1:0] q_next   [SQRT_STAGES];
    logic [NUM_BITS-1:0]  n_next   [SQRT_STAGES];

    always_comb
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            logic [ROOT_BITS+1:0] rem_in;
            logic [ROOT_BITS-1:0] q_in;
            logic [NUM_BITS-1:0]  n_in;
            logic [ROOT_BITS+3:0] rem_sh;
            logic [ROOT_BITS+3:0] trial;
            if (s == 0)
            begin
                rem_in = '0;
                q_in   = '0;
                n_in   = radicand;
            end
            else
            begin
                rem_in = rem_reg[s-1];
                q_in   = q_reg[s-1];
                n_in   = n_reg[s-1];
            end
            rem_sh = {rem_in, n_in[NUM_BITS-1 -: 2]};
            trial  = {2'b00, q_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next[s] = (ROOT_BITS+2)'(rem_sh - trial);
                q_next[s]   = {q_in[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = rem_sh[ROOT_BITS+1:0];
                q_next[s]   = {q_in[ROOT_BITS-2:0], 1'b0};
            end
            n_next[s] = {n_in[NUM_BITS-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SQRT_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < SQRT_STAGES; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int s = 1; s < SQRT_STAGES; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            rem_reg <= rem_next;
            q_reg   <= q_next;
            n_reg   <= n_next;
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign root      = q_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

[rtl/psw_div.sv]
// ----------------------------------------------------------------------------
// psw_div
// four-lane pipelined restoring divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
module psw_div
    import psw_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [LANES-1:0][NUM_BITS-1:0] num,
    input  logic [ROOT_BITS-1:0]           divisor,
    input  psw_side_t                      in_side,
    output logic                           out_valid,
    output logic [LANES-1:0][NUM_BITS-1:0] quot,
    output psw_side_t                      out_side
);

    logic                            v_reg    [DIV_STAGES];
    logic [LANES-1:0][ROOT_BITS-1:0] rem_reg  [DIV_STAGES];
    logic [LANES-1:0][NUM_BITS-1:0]  nq_reg   [DIV_STAGES];
    logic [LANES-1:0]                neg_reg  [DIV_STAGES];
    logic [ROOT_BITS-1:0]            d_reg    [DIV_STAGES];
    psw_side_t                       side_reg [DIV_STAGES];

    logic [LANES-1:0][ROOT_BITS-1:0] rem_next [DIV_STAGES];
    logic [LANES-1:0][NUM_BITS-1:0]  nq_next  [DIV_STAGES];

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic [ROOT_BITS-1:0] rem_in;
                logic [NUM_BITS-1:0]  nq_in;
                logic [ROOT_BITS-1:0] d_in;
                logic [ROOT_BITS:0]   rem_sh;
                if (s == 0)
                begin
                    rem_in = '0;
                    nq_in  = num[l][NUM_BITS-1] ? (~num[l] + 1'b1) : num[l];
                    d_in   = divisor;
                end
                else
                begin
                    rem_in = rem_reg[s-1][l];
                    nq_in  = nq_reg[s-1][l];
                    d_in   = d_reg[s-1];
                end
                rem_sh = {rem_in, nq_in[NUM_BITS-1]};
                if (rem_sh >= {1'b0, d_in})
                begin
                    rem_next[s][l] = ROOT_BITS'(rem_sh - {1'b0, d_in});
                    nq_next[s][l]  = {nq_in[NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][l] = rem_sh[ROOT_BITS-1:0];
                    nq_next[s][l]  = {nq_in[NUM_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            d_reg[0]    <= divisor;
            for (int l = 0; l < LANES; l++)
            begin
                neg_reg[0][l] <= num[l][NUM_BITS-1];
            end
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                side_reg[s] <= side_reg[s-1];
                d_reg[s]    <= d_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
            end
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quot[l] = neg_reg[DIV_STAGES-1][l] ? (~nq_reg[DIV_STAGES-1][l] + 1'b1)
                                               : nq_reg[DIV_STAGES-1][l];
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

[rtl/pointwise_scalar_wave_flux_core.sv]
// ----------------------------------------------------------------------------
// pointwise_scalar_wave_flux_core
// per-point scalar wave fluxes on a curved 3-metric, signed q16.16
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | metric pairs, lapse, shift, momentum, grad
//  output   | out_valid / out_ready | flux_mom_x/y/z, flux_field, bad_metric
//
//  one beat per cycle sustained while the output is taken; 5 front, 32 square root,
//  64 divider stages and 1 output register, set by the bit-per-stage root and divider
//  all stages advance together; a held output beat freezes the whole pipe
//  and drops in_ready, so nothing is lost or repeated, bubbles stay in place
//  reset clears only the valid bits; data registers are left as they are
// ----------------------------------------------------------------------------
`include "pointwise_scalar_wave_flux_core_defines.svh"

module pointwise_scalar_wave_flux_core
    import psw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] metric_xx_xy,
    input  logic [63:0] metric_xz_yy,
    input  logic [63:0] metric_yz_zz,
    input  word_t       lapse,
    input  word_t       shift_x,
    input  word_t       shift_y,
    input  word_t       shift_z,
    input  word_t       momentum,
    input  word_t       grad_x,
    input  word_t       grad_y,
    input  word_t       grad_z,
    output logic        out_valid,
    input  logic        out_ready,
    output word_t       flux_mom_x,
    output word_t       flux_mom_y,
    output word_t       flux_mom_z,
    output word_t       flux_field,
    output logic        bad_metric
);

    // pipe enable: advance whenever the output register is free or being taken
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // front end: cofactors, determinant, dot products, numerators
    logic                f_valid;
    logic [NUM_BITS-1:0] f_rad;
    psw_root_side_t      f_side;

    psw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .metric_xx_xy (metric_xx_xy),
        .metric_xz_yy (metric_xz_yy),
        .metric_yz_zz (metric_yz_zz),
        .lapse        (lapse),
        .shift_x      (shift_x),
        .shift_y      (shift_y),
        .shift_z      (shift_z),
        .momentum     (momentum),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .grad_z       (grad_z),
        .out_valid    (f_valid),
        .radicand     (f_rad),
        .out_side     (f_side)
    );

    // square root of det scaled by 2^16
    logic                 s_valid;
    logic [ROOT_BITS-1:0] s_root;
    psw_root_side_t       s_side;

    psw_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .radicand  (f_rad),
        .in_side   (f_side),
        .out_valid (s_valid),
        .root      (s_root),
        .out_side  (s_side)
    );

    // four quotients by the root; a bad metric gives a zero or unusable divisor, masked below
    logic                           d_valid;
    logic [LANES-1:0][NUM_BITS-1:0] d_quot;
    psw_side_t                      d_side;

    psw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .num       (s_side.num),
        .divisor   (s_root),
        .in_side   (s_side.side),
        .out_valid (d_valid),
        .quot      (d_quot),
        .out_side  (d_side)
    );

    // final subtraction and saturation into the output register
    word_t fx_reg, fy_reg, fz_reg, ff_reg;
    logic  bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad_reg <= d_side.bad;
            if (d_side.bad)
            begin
                fx_reg <= '0;
                fy_reg <= '0;
                fz_reg <= '0;
                ff_reg <= '0;
            end
            else
            begin
                fx_reg <= sat_word($signed(d_quot[0]) - 64'(d_side.sbp_x));
                fy_reg <= sat_word($signed(d_quot[1]) - 64'(d_side.sbp_y));
                fz_reg <= sat_word($signed(d_quot[2]) - 64'(d_side.sbp_z));
                ff_reg <= sat_word($signed(d_quot[3]) - 64'(d_side.sdot));
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign flux_mom_x = fx_reg;
    assign flux_mom_y = fy_reg;
    assign flux_mom_z = fz_reg;
    assign flux_field = ff_reg;
    assign bad_metric = bad_reg;

    // a bad metric beat carries zero fluxes
    `PSW_ASSERT_IMP(a_bad_zero, out_valid && bad_metric,
        flux_mom_x == 0 && flux_mom_y == 0 && flux_mom_z == 0 && flux_field == 0)
    // a positive determinant never leaves a zero root
    `PSW_ASSERT_IMP(a_root_nonzero, s_valid && !s_side.side.bad, s_root != 0)
    // held output beat keeps its value
    `PSW_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(flux_field) && $stable(bad_metric))

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pointwise scalar wave flux core: each point
// beat is scored by a behavioural fixed-point predictor, results are matched
// in order under random source gaps, sink stalls and a long sink hold-off
// ----------------------------------------------------------------------------
module tb_top;
    import psw_pkg::*;

    localparam int LATENCY     = 102;
    localparam int STALL_LIMIT = 5000;   // cycles with no beat on either side
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [63:0] m0, m1, m2;
        word_t       alp, bx, by, bz, pi, gx, gy, gz;
    } point_t;

    typedef struct {
        word_t fx, fy, fz, ff;
        logic  bad;
    } flux_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] metric_xx_xy = '0, metric_xz_yy = '0, metric_yz_zz = '0;
    word_t       lapse = '0, shift_x = '0, shift_y = '0, shift_z = '0;
    word_t       momentum = '0, grad_x = '0, grad_y = '0, grad_z = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    word_t       flux_mom_x, flux_mom_y, flux_mom_z, flux_field;
    logic        bad_metric;

    flux_t       expected_flux[$];
    int          mismatches = 0;
    int          points_sent = 0;
    int          fluxes_seen = 0;
    int          bad_seen = 0;
    int          hold_cycles = 0;
    int          burst_left = 0;
    bit          source_gaps = 1'b1;

    always #1 clk = ~clk;

    pointwise_scalar_wave_flux_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .metric_xx_xy (metric_xx_xy),
        .metric_xz_yy (metric_xz_yy),
        .metric_yz_zz (metric_yz_zz),
        .lapse        (lapse),
        .shift_x      (shift_x),
        .shift_y      (shift_y),
        .shift_z      (shift_z),
        .momentum     (momentum),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .grad_z       (grad_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .flux_mom_x   (flux_mom_x),
        .flux_mom_y   (flux_mom_y),
        .flux_mom_z   (flux_mom_z),
        .flux_field   (flux_field),
        .bad_metric   (bad_metric)
    );

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // q16.16 product, floored
    function automatic longint fmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    // clamp to the signed saturation width
    function automatic longint clamp_word(input longint v);
        if (v > SAT_MAX)
        begin
            return SAT_MAX;
        end
        if (v < SAT_MIN)
        begin
            return SAT_MIN;
        end
        return v;
    endfunction

    // bit-pair integer square root
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic flux_t point_flux(input point_t p);
        longint xx, xy, xz, yy, yz, zz, alp, pi;
        longint cxx, cxy, cxz, cyy, cyz, czz, det, root, dx, dy, dz;
        flux_t  f;
        xx  = $signed(p.m0[31:0]);
        xy  = $signed(p.m0[63:32]);
        xz  = $signed(p.m1[31:0]);
        yy  = $signed(p.m1[63:32]);
        yz  = $signed(p.m2[31:0]);
        zz  = $signed(p.m2[63:32]);
        alp = p.alp;
        pi  = p.pi;
        cxx = clamp_word(fmul(yy, zz) - fmul(yz, yz));
        cxy = clamp_word(fmul(xz, yz) - fmul(xy, zz));
        cxz = clamp_word(fmul(xy, yz) - fmul(xz, yy));
        cyy = clamp_word(fmul(xx, zz) - fmul(xz, xz));
        cyz = clamp_word(fmul(xy, xz) - fmul(xx, yz));
        czz = clamp_word(fmul(xx, yy) - fmul(xy, xy));
        det = fmul(xx, cxx) + fmul(xy, cxy) + fmul(xz, cxz);
        f = '{default: '0};
        if (det <= 0)
        begin
            f.bad = 1'b1;
            return f;
        end
        root = longint'(int_sqrt(longint'(unsigned'(det)) << FRAC_BITS));
        dx = clamp_word(fmul(cxx, p.gx) + fmul(cxy, p.gy) + fmul(cxz, p.gz));
        dy = clamp_word(fmul(cxy, p.gx) + fmul(cyy, p.gy) + fmul(cyz, p.gz));
        dz = clamp_word(fmul(cxz, p.gx) + fmul(cyz, p.gy) + fmul(czz, p.gz));
        f.fx = word_t'(clamp_word((alp * dx) / root - fmul(p.bx, pi)));
        f.fy = word_t'(clamp_word((alp * dy) / root - fmul(p.by, pi)));
        f.fz = word_t'(clamp_word((alp * dz) / root - fmul(p.bz, pi)));
        f.ff = word_t'(clamp_word((alp * pi) / root - (fmul(p.bx, p.gx)
                       + fmul(p.by, p.gy) + fmul(p.bz, p.gz))));
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------------

    // one point beat; valid stays up across back-to-back beats
    task automatic send_point(input point_t p);
        int gap;
        if (source_gaps && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        @(negedge clk);
        metric_xx_xy = p.m0;
        metric_xz_yy = p.m1;
        metric_yz_zz = p.m2;
        lapse    = p.alp;
        shift_x  = p.bx;
        shift_y  = p.by;
        shift_z  = p.bz;
        momentum = p.pi;
        grad_x   = p.gx;
        grad_y   = p.gy;
        grad_z   = p.gz;
        in_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expected_flux.push_back(point_flux(p));
        points_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [63:0] pack2(input word_t lo, input word_t hi);
        return {hi, lo};
    endfunction

    function automatic word_t rand_word();
        return word_t'($urandom);
    endfunction

    // q16.16 value around +-range/65536 with a random fraction
    function automatic word_t rand_near(input int range);
        return word_t'($urandom_range(0, 2 * range) - range);
    endfunction

    function automatic point_t make_point(input word_t xx, input word_t xy, input word_t xz,
                                          input word_t yy, input word_t yz, input word_t zz,
                                          input word_t alp, input word_t b, input word_t pi,
                                          input word_t g);
        point_t p;
        p.m0 = pack2(xx, xy);
        p.m1 = pack2(xz, yy);
        p.m2 = pack2(yz, zz);
        p.alp = alp;
        p.bx = b;
        p.by = -b;
        p.bz = b >>> 1;
        p.pi = pi;
        p.gx = g;
        p.gy = g >>> 3;
        p.gz = -g;
        return p;
    endfunction

    // mostly a positive-definite metric with random content, some raw noise
    function automatic point_t random_point();
        point_t p;
        int     kind, mag;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            p.m0 = {$urandom, $urandom};
            p.m1 = {$urandom, $urandom};
            p.m2 = {$urandom, $urandom};
        end
        else
        begin
            mag = (kind < 85) ? 32'h0004_0000 : 32'h0100_0000;
            p.m0 = pack2(word_t'($urandom_range(32'h0000_4000, mag)),
                         rand_near(32'h0000_4000));
            p.m1 = pack2(rand_near(32'h0000_4000),
                         word_t'($urandom_range(32'h0000_4000, mag)));
            p.m2 = pack2(rand_near(32'h0000_4000),
                         word_t'($urandom_range(32'h0000_4000, mag)));
            if (kind >= 95)
            begin
                // occasional near-singular or indefinite metric
                p.m1[63:32] = rand_near(32'h0000_0100);
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            p.alp = rand_word();
            p.bx  = rand_word();
            p.by  = rand_word();
            p.bz  = rand_word();
            p.pi  = rand_word();
            p.gx  = rand_word();
            p.gy  = rand_word();
            p.gz  = rand_word();
        end
        else
        begin
            p.alp = rand_near(32'h0004_0000);
            p.bx  = rand_near(32'h0002_0000);
            p.by  = rand_near(32'h0002_0000);
            p.bz  = rand_near(32'h0002_0000);
            p.pi  = rand_near(32'h0010_0000);
            p.gx  = rand_near(32'h0010_0000);
            p.gy  = rand_near(32'h0010_0000);
            p.gz  = rand_near(32'h0010_0000);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // sink side: own stall pattern plus an optional long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        int mode, left;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(50, 300);
            end
            left--;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready = 1'b0;
            end
            else if (mode == 0)
            begin
                out_ready = 1'b1;                       // no stalls at all
            end
            else if (mode == 1)
            begin
                out_ready = ($urandom_range(0, 1) == 1);
            end
            else
            begin
                out_ready = (left % 9) < 6;             // periodic stall bursts
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker, in arrival order
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        flux_t want;
        if (rst_n && out_valid && out_ready)
        begin
            fluxes_seen++;
            if (expected_flux.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("error: flux beat with nothing expected");
                end
            end
            else
            begin
                want = expected_flux.pop_front();
                bad_seen += want.bad;
                if (flux_mom_x !== want.fx || flux_mom_y !== want.fy ||
                    flux_mom_z !== want.fz || flux_field !== want.ff ||
                    bad_metric !== want.bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("error: beat %0d exp %h %h %h %h %b got %h %h %h %h %b",
                                 fluxes_seen, want.fx, want.fy, want.fz, want.ff, want.bad,
                                 flux_mom_x, flux_mom_y, flux_mom_z, flux_field, bad_metric);
                    end
                end
            end
        end
    end

    // watchdog: too long without any beat on either side
    initial
    begin
        int idle;
        idle = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
            if (idle >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", idle);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (expected_flux.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    localparam word_t ONE  = 32'sh0001_0000;
    localparam word_t WMAX = 32'sh7fff_ffff;
    localparam word_t WMIN = 32'sh8000_0000;

    task automatic test_directed_extremes();
        // identity metric, plain values
        send_point(make_point(ONE, 0, 0, ONE, 0, ONE, ONE, ONE, ONE, ONE));
        // all-zero point: zero determinant
        send_point(make_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // negative definite diagonal: negative determinant
        send_point(make_point(-ONE, 0, 0, -ONE, 0, -ONE, ONE, ONE, ONE, ONE));
        // singular metric with equal rows
        send_point(make_point(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        // largest and smallest words everywhere
        send_point(make_point(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
        send_point(make_point(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN));
        // huge diagonal: cofactors saturate, lapse and gradient at the ends
        send_point(make_point(WMAX, 0, 0, WMAX, 0, WMAX, WMAX, WMIN, WMAX, WMIN));
        send_point(make_point(WMAX, 0, 0, WMAX, 0, WMAX, WMIN, WMAX, WMIN, WMAX));
        // tiny diagonal: the determinant floors to zero, so the point is flagged bad
        send_point(make_point(32'sh100, 0, 0, 32'sh100, 0, 32'sh100,
                              WMAX, 0, WMAX, WMAX));
        send_point(make_point(32'sh100, 0, 0, 32'sh100, 0, 32'sh100,
                              WMIN, 0, WMAX, WMIN));
        // shift term alone drives the fluxes to both rails
        send_point(make_point(ONE, 0, 0, ONE, 0, ONE, 0, WMAX, WMAX, WMAX));
        send_point(make_point(ONE, 0, 0, ONE, 0, ONE, 0, WMIN, WMAX, WMIN));
        // off-diagonal coupling, negative fractions
        send_point(make_point(2 * ONE, -ONE / 2, ONE / 4, 3 * ONE, -ONE / 3, ONE,
                              -ONE / 2, -3, -7, -1));
        // every bit of every field
        send_point('{m0: '1, m1: '1, m2: '1, alp: -1, bx: -1, by: -1, bz: -1,
                     pi: -1, gx: -1, gy: -1, gz: -1});
        send_point('{m0: {2{32'h5555_5555}}, m1: {2{32'haaaa_aaaa}},
                     m2: {2{32'h5555_5555}}, alp: 32'sh5555_5555,
                     bx: 32'shaaaa_aaaa, by: 32'sh5555_5555, bz: 32'shaaaa_aaaa,
                     pi: 32'sh5555_5555, gx: 32'shaaaa_aaaa, gy: 32'sh5555_5555,
                     gz: 32'shaaaa_aaaa});
        drop_valid();
    endtask

    task automatic test_random_points(input int count, input bit gappy);
        source_gaps = gappy;
        burst_left = 0;
        repeat (count) send_point(random_point());
        drop_valid();
        source_gaps = 1'b1;
    endtask

    // sink holds off while the source keeps offering, so the pipe fills
    task automatic test_long_hold();
        @(negedge clk);
        hold_cycles = LONG_HOLD;
        source_gaps = 1'b0;
        repeat (250) send_point(random_point());
        drop_valid();
        source_gaps = 1'b1;
    endtask

    // source pauses until every flux is back, then resumes
    task automatic test_drain_pause();
        test_random_points(60, 1'b1);
        wait_drained();
        test_random_points(60, 1'b0);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_extremes();
        test_random_points(400, 1'b1);
        test_long_hold();
        test_random_points(300, 1'b0);
        test_drain_pause();
        test_random_points(380, 1'b1);

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (expected_flux.size() != 0)
        begin
            mismatches++;
        end
        $display("covered %0d point beats, %0d flux beats, %0d flagged bad metric",
                 points_sent, fluxes_seen, bad_seen);
        $display("with source gaps, sink stalls, a long sink hold and a full drain");
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/psw_pkg.sv
rtl/psw_front.sv
rtl/psw_sqrt.sv
rtl/psw_div.sv
rtl/pointwise_scalar_wave_flux_core.sv
tb/sv/tb_top.sv
